/* rtl/gpm_pkg.sv */
`default_nettype none

package gpm_pkg;

   // fixed field widths
   localparam int REG_BITS  = 20;
   localparam int LIM_BITS  = 20;
   localparam int ID_BITS   = 16;
   localparam int KIND_BITS = 2;
   localparam int STAT_BITS = 2;
   localparam int CSR_BITS  = 2;
   localparam int SQ_W      = 2 * LIM_BITS;
   localparam int SUM_W     = SQ_W + 2;

   // 9999 cm ceiling in 0.1 mm units
   localparam logic [LIM_BITS-1:0] DIST_CEIL = LIM_BITS'(999900);
   localparam logic [REG_BITS-1:0] MAX_DIST_RESET = REG_BITS'(100);

   // item kinds
   localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LOAD  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_TRAJ  = 2'd2;

   // result status codes
   localparam logic [STAT_BITS-1:0] STAT_MATCH   = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_NONE    = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_SKIPPED = 2'd2;

   // register indexes
   localparam logic [CSR_BITS-1:0] CSR_MAX_DIST = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_START_X  = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_START_Y  = 2'd2;
   localparam logic [CSR_BITS-1:0] CSR_START_Z  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic kill;
      logic rotate;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* rtl/gpm_cell.sv */
`default_nettype none

module gpm_cell #(
   parameter int COORD_BITS = 20
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gpm_pkg::cell_ctrl_type          ctrl,
   input  wire logic signed [COORD_BITS-1:0]    load_x,
   input  wire logic signed [COORD_BITS-1:0]    load_y,
   input  wire logic signed [COORD_BITS-1:0]    load_z,
   input  wire logic [gpm_pkg::ID_BITS-1:0]     load_id,
   input  wire logic signed [COORD_BITS-1:0]    nxt_x,
   input  wire logic signed [COORD_BITS-1:0]    nxt_y,
   input  wire logic signed [COORD_BITS-1:0]    nxt_z,
   input  wire logic [gpm_pkg::ID_BITS-1:0]     nxt_id,
   input  wire logic                            nxt_live,
   output logic signed [COORD_BITS-1:0]         x,
   output logic signed [COORD_BITS-1:0]         y,
   output logic signed [COORD_BITS-1:0]         z,
   output logic [gpm_pkg::ID_BITS-1:0]          id,
   output logic                                 live
);
   import gpm_pkg::*;

   logic signed [COORD_BITS-1:0] x_ff, y_ff, z_ff;
   logic signed [COORD_BITS-1:0] x_in, y_in, z_in;
   logic [ID_BITS-1:0]           id_ff, id_in;
   logic                         live_ff, live_in;

   always_comb begin
      x_in  = x_ff;
      y_in  = y_ff;
      z_in  = z_ff;
      id_in = id_ff;
      if (ctrl.load) begin
         x_in  = load_x;
         y_in  = load_y;
         z_in  = load_z;
         id_in = load_id;
      end else if (ctrl.rotate) begin
         x_in  = nxt_x;
         y_in  = nxt_y;
         z_in  = nxt_z;
         id_in = nxt_id;
      end
   end

   always_comb begin
      live_in = live_ff;
      if (ctrl.clear) begin
         live_in = 1'b0;
      end else if (ctrl.load) begin
         live_in = 1'b1;
      end else if (ctrl.kill) begin
         live_in = 1'b0;
      end else if (ctrl.rotate) begin
         live_in = nxt_live;
      end
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      y_ff  <= y_in;
      z_ff  <= z_in;
      id_ff <= id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
   end

   assign x    = x_ff;
   assign y    = y_ff;
   assign z    = z_ff;
   assign id   = id_ff;
   assign live = live_ff;

endmodule

`default_nettype wire

/* rtl/gpm_dist.sv */
`default_nettype none

module gpm_dist #(
   parameter int COORD_BITS = 20,
   parameter int IDX_W      = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            init,
   input  wire logic                            valid_in,
   input  wire logic                            live_in,
   input  wire logic signed [COORD_BITS-1:0]    sx,
   input  wire logic signed [COORD_BITS-1:0]    sy,
   input  wire logic signed [COORD_BITS-1:0]    sz,
   input  wire logic [gpm_pkg::ID_BITS-1:0]     sid,
   input  wire logic [IDX_W-1:0]                idx,
   input  wire logic signed [COORD_BITS-1:0]    qx,
   input  wire logic signed [COORD_BITS-1:0]    qy,
   input  wire logic signed [COORD_BITS-1:0]    qz,
   input  wire logic [gpm_pkg::LIM_BITS-1:0]    lim,
   output logic                                 found,
   output logic [gpm_pkg::ID_BITS-1:0]          best_id,
   output logic [IDX_W-1:0]                     best_idx
);
   import gpm_pkg::*;

   localparam int DIF_W = COORD_BITS + 1;
   localparam int ABS_W = (DIF_W > LIM_BITS) ? DIF_W : LIM_BITS;

   // stage a: signed differences
   logic                    va_ff;
   logic signed [DIF_W-1:0] dx_a_ff, dy_a_ff, dz_a_ff;
   logic [ID_BITS-1:0]      id_a_ff;
   logic [IDX_W-1:0]        idx_a_ff;

   // stage b: magnitudes within the per-axis bound
   logic                    vb_ff, vb_in;
   logic [LIM_BITS-1:0]     dx_b_ff, dy_b_ff, dz_b_ff;
   logic [ID_BITS-1:0]      id_b_ff;
   logic [IDX_W-1:0]        idx_b_ff;
   logic signed [DIF_W-1:0] nx, ny, nz;
   logic [ABS_W-1:0]        ax, ay, az, lim_ext;

   // stage c: squares
   logic                    vc_ff;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff, sqz_ff;
   logic [ID_BITS-1:0]      id_c_ff;
   logic [IDX_W-1:0]        idx_c_ff;

   // running best
   logic [SUM_W-1:0]        best_ff, d2;
   logic                    found_ff;
   logic [ID_BITS-1:0]      best_id_ff;
   logic [IDX_W-1:0]        best_idx_ff;
   logic                    better;

   always_ff @(posedge clock) begin
      dx_a_ff  <= DIF_W'(sx) - DIF_W'(qx);
      dy_a_ff  <= DIF_W'(sy) - DIF_W'(qy);
      dz_a_ff  <= DIF_W'(sz) - DIF_W'(qz);
      id_a_ff  <= sid;
      idx_a_ff <= idx;
   end

   always_comb begin
      nx      = -dx_a_ff;
      ny      = -dy_a_ff;
      nz      = -dz_a_ff;
      ax      = ABS_W'(dx_a_ff[DIF_W-1] ? $unsigned(nx) : $unsigned(dx_a_ff));
      ay      = ABS_W'(dy_a_ff[DIF_W-1] ? $unsigned(ny) : $unsigned(dy_a_ff));
      az      = ABS_W'(dz_a_ff[DIF_W-1] ? $unsigned(nz) : $unsigned(dz_a_ff));
      lim_ext = ABS_W'(lim);
      vb_in   = va_ff && (ax < lim_ext) && (ay < lim_ext) && (az < lim_ext);
   end

   always_ff @(posedge clock) begin
      dx_b_ff  <= ax[LIM_BITS-1:0];
      dy_b_ff  <= ay[LIM_BITS-1:0];
      dz_b_ff  <= az[LIM_BITS-1:0];
      id_b_ff  <= id_a_ff;
      idx_b_ff <= idx_a_ff;
   end

   always_ff @(posedge clock) begin
      sqx_ff   <= SQ_W'(dx_b_ff) * SQ_W'(dx_b_ff);
      sqy_ff   <= SQ_W'(dy_b_ff) * SQ_W'(dy_b_ff);
      sqz_ff   <= SQ_W'(dz_b_ff) * SQ_W'(dz_b_ff);
      id_c_ff  <= id_b_ff;
      idx_c_ff <= idx_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= valid_in && live_in;
         vb_ff <= vb_in;
         vc_ff <= vb_ff;
      end
   end

   // strict compare keeps the earliest entry on ties
   always_comb begin
      d2     = SUM_W'(sqx_ff) + SUM_W'(sqy_ff) + SUM_W'(sqz_ff);
      better = vc_ff && (d2 < best_ff);
   end

   always_ff @(posedge clock) begin
      if (init) begin
         best_ff <= SUM_W'(SQ_W'(lim) * SQ_W'(lim));
      end else if (better) begin
         best_ff     <= d2;
         best_id_ff  <= id_c_ff;
         best_idx_ff <= idx_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || init) begin
         found_ff <= 1'b0;
      end else if (better) begin
         found_ff <= 1'b1;
      end
   end

   assign found    = found_ff;
   assign best_id  = best_id_ff;
   assign best_idx = best_idx_ff;

endmodule

`default_nettype wire

/* rtl/greedy_point_matcher.sv */
`default_nettype none

// channel  | dir | ports            | content
// req      | in  | tdata            | pos_x, pos_y, pos_z, point_id (zero padded)
//          |     | tuser            | kind, no_point, first_of_track
// rsp      | out | tdata            | match_id
//          |     | tuser            | status
// csr      | in  | we, index, wdata | max_distance, start_x, start_y, start_z
//
// clear and load items are taken in idle and can follow back to back.
// a trajectory item runs through check, scan, drain and finish: the stored points circulate
// once around the ring of cells past a single 4-stage distance unit.
// a skipped trajectory item returns from check to idle without a scan.
// synchronous reset empties the store, no clearing pass is needed.
// a result held in the output register stalls only the next trajectory result.

module greedy_point_matcher #(
   parameter int STORE_DEPTH = 256,
   parameter int COORD_BITS  = 20
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // pos_x, pos_y, pos_z, point_id, zero pad
   input  wire logic [((3*COORD_BITS+gpm_pkg::ID_BITS+7)/8)*8-1:0] req_tdata,
   // kind[1:0], no_point, first_of_track
   input  wire logic [3:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // match_id
   output logic [gpm_pkg::ID_BITS-1:0]          rsp_tdata,
   // status
   output logic [gpm_pkg::STAT_BITS-1:0]        rsp_tuser,
   input  wire logic                            csr_we,
   input  wire logic [gpm_pkg::CSR_BITS-1:0]    csr_index,
   input  wire logic [gpm_pkg::REG_BITS-1:0]    csr_wdata
);
   import gpm_pkg::*;

   localparam int IDX_W     = $clog2(STORE_DEPTH);
   localparam int FILL_W    = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W     = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
   localparam int DRAIN_LEN = 3;

   // request unpacking
   logic [KIND_BITS-1:0]         req_kind;
   logic signed [COORD_BITS-1:0] req_x, req_y, req_z;
   logic [ID_BITS-1:0]           req_id;
   logic                         req_nopt, req_first, req_go;

   assign req_x     = $signed(req_tdata[COORD_BITS-1:0]);
   assign req_y     = $signed(req_tdata[2*COORD_BITS-1:COORD_BITS]);
   assign req_z     = $signed(req_tdata[3*COORD_BITS-1:2*COORD_BITS]);
   assign req_id    = req_tdata[3*COORD_BITS+ID_BITS-1:3*COORD_BITS];
   assign req_kind  = req_tuser[1:0];
   assign req_nopt  = req_tuser[2];
   assign req_first = req_tuser[3];
   assign req_go    = req_tvalid && req_tready;

   // configuration
   logic [REG_BITS-1:0]        max_dist_ff;
   logic signed [REG_BITS-1:0] start_x_ff, start_y_ff, start_z_ff;
   logic [LIM_BITS-1:0]        lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= MAX_DIST_RESET;
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         start_z_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_DIST: max_dist_ff <= csr_wdata;
            CSR_START_X:  start_x_ff  <= $signed(csr_wdata);
            CSR_START_Y:  start_y_ff  <= $signed(csr_wdata);
            CSR_START_Z:  start_z_ff  <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   assign lim = (LIM_BITS'(max_dist_ff) < DIST_CEIL) ? LIM_BITS'(max_dist_ff) : DIST_CEIL;

   // query and reference location
   logic signed [COORD_BITS-1:0] q_x_ff, q_y_ff, q_z_ff;
   logic                         q_nopt_ff;
   logic signed [COORD_BITS-1:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic                         traj_go, load_go, clear_go;

   assign traj_go  = req_go && (req_kind == KIND_TRAJ);
   assign load_go  = req_go && (req_kind == KIND_LOAD);
   assign clear_go = req_go && (req_kind == KIND_CLEAR);

   always_ff @(posedge clock) begin
      if (req_go) begin
         q_x_ff    <= req_x;
         q_y_ff    <= req_y;
         q_z_ff    <= req_z;
         q_nopt_ff <= req_nopt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
         ref_z_ff <= '0;
      end else if (traj_go && req_first) begin
         ref_x_ff <= req_x;
         ref_y_ff <= req_y;
         ref_z_ff <= req_z;
      end
   end

   logic eq_ref, eq_start, skip;

   assign eq_ref   = (q_x_ff == ref_x_ff) && (q_y_ff == ref_y_ff) && (q_z_ff == ref_z_ff);
   assign eq_start = (CMP_W'(q_x_ff) == CMP_W'(start_x_ff)) &&
                     (CMP_W'(q_y_ff) == CMP_W'(start_y_ff)) &&
                     (CMP_W'(q_z_ff) == CMP_W'(start_z_ff));
   assign skip     = q_nopt_ff || eq_ref || eq_start;

   // fill count
   logic [FILL_W-1:0] fill_ff;
   logic              load_ok;

   assign load_ok = load_go && (fill_ff < FILL_W'(STORE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset || clear_go) begin
         fill_ff <= '0;
      end else if (load_ok) begin
         fill_ff <= fill_ff + FILL_W'(1);
      end
   end

   // sequencer
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             slot_free, emit, rotate, dist_init, kill_go;
   logic [STAT_BITS-1:0] emit_status;
   logic             found;
   logic [ID_BITS-1:0] best_id;
   logic [IDX_W-1:0] best_idx;

   assign slot_free = !rsp_tvalid || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (traj_go) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!skip) begin
               state_in = ST_SCAN;
            end else if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == IDX_W'(STORE_DEPTH - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (cnt_ff == IDX_W'(DRAIN_LEN - 1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      emit        = 1'b0;
      emit_status = STAT_SKIPPED;
      rotate      = 1'b0;
      dist_init   = 1'b0;
      kill_go     = 1'b0;
      cnt_in      = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_CHECK: begin
            dist_init = !skip;
            emit      = skip && slot_free;
         end
         ST_SCAN: begin
            rotate = 1'b1;
            if (cnt_ff != IDX_W'(STORE_DEPTH - 1)) cnt_in = cnt_ff + IDX_W'(1);
         end
         ST_DRAIN: begin
            if (cnt_ff != IDX_W'(DRAIN_LEN - 1)) cnt_in = cnt_ff + IDX_W'(1);
         end
         ST_FINISH: begin
            emit        = slot_free;
            emit_status = found ? STAT_MATCH : STAT_NONE;
            kill_go     = slot_free && found;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // ring of cells, cell 0 feeds the distance unit
   logic signed [COORD_BITS-1:0] cell_x [STORE_DEPTH];
   logic signed [COORD_BITS-1:0] cell_y [STORE_DEPTH];
   logic signed [COORD_BITS-1:0] cell_z [STORE_DEPTH];
   logic [ID_BITS-1:0]           cell_id [STORE_DEPTH];
   logic                         cell_live [STORE_DEPTH];
   cell_ctrl_type                cell_ctrl [STORE_DEPTH];

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      localparam int NXT = (i + 1) % STORE_DEPTH;

      always_comb begin
         cell_ctrl[i].clear  = clear_go;
         cell_ctrl[i].load   = load_ok && (fill_ff[IDX_W-1:0] == IDX_W'(i));
         cell_ctrl[i].kill   = kill_go && (best_idx == IDX_W'(i));
         cell_ctrl[i].rotate = rotate;
      end

      gpm_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl[i]),
         .load_x   (req_x),
         .load_y   (req_y),
         .load_z   (req_z),
         .load_id  (req_id),
         .nxt_x    (cell_x[NXT]),
         .nxt_y    (cell_y[NXT]),
         .nxt_z    (cell_z[NXT]),
         .nxt_id   (cell_id[NXT]),
         .nxt_live (cell_live[NXT]),
         .x        (cell_x[i]),
         .y        (cell_y[i]),
         .z        (cell_z[i]),
         .id       (cell_id[i]),
         .live     (cell_live[i])
      );
   end

   gpm_dist #(
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .init     (dist_init),
      .valid_in (rotate),
      .live_in  (cell_live[0]),
      .sx       (cell_x[0]),
      .sy       (cell_y[0]),
      .sz       (cell_z[0]),
      .sid      (cell_id[0]),
      .idx      (cnt_ff),
      .qx       (q_x_ff),
      .qy       (q_y_ff),
      .qz       (q_z_ff),
      .lim      (lim),
      .found    (found),
      .best_id  (best_id),
      .best_idx (best_idx)
   );

   // output register
   logic                 rsp_valid_ff;
   logic [STAT_BITS-1:0] rsp_status_ff;
   logic [ID_BITS-1:0]   rsp_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_id_ff     <= (emit_status == STAT_MATCH) ? best_id : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_id_ff;

endmodule

`default_nettype wire
